// ===== rtl/core/cstuv_pkg.sv =====
// shared types, constants and functions for the spherical uv projector
`default_nettype none
package cstuv_pkg;

  localparam int ITERS = 32;
  localparam int DW    = 60;            // datapath width for scaled magnitudes
  localparam int AW    = 34;            // angle width, units of pi*2^-31
  localparam logic [31:0] GAIN_Q30 = 32'd1768195363;

  typedef logic signed [DW-1:0] dat_t;
  typedef logic signed [AW-1:0] ang_t;

  // per-point side information carried down the cell row
  typedef struct packed {
    logic valid;
    logic err;
    logic xn;
    logic yn;
    logic zn;
    logic ax_zero;
    logic az_zero;
    logic ay_zero;
  } tag_t;

  // atan(2^-i)/pi in Q31, rounded half up
  function automatic ang_t atan_tab(input int i);
    logic [31:0] t [0:31];
    t[0]  = 32'd536870912; t[1]  = 32'd316933406; t[2]  = 32'd167458907;
    t[3]  = 32'd85004756;  t[4]  = 32'd42667331;  t[5]  = 32'd21354465;
    t[6]  = 32'd10679838;  t[7]  = 32'd5340245;   t[8]  = 32'd2670163;
    t[9]  = 32'd1335087;   t[10] = 32'd667544;    t[11] = 32'd333772;
    t[12] = 32'd166886;    t[13] = 32'd83443;     t[14] = 32'd41722;
    t[15] = 32'd20861;     t[16] = 32'd10430;     t[17] = 32'd5215;
    t[18] = 32'd2608;      t[19] = 32'd1304;      t[20] = 32'd652;
    t[21] = 32'd326;       t[22] = 32'd163;       t[23] = 32'd81;
    t[24] = 32'd41;        t[25] = 32'd20;        t[26] = 32'd10;
    t[27] = 32'd5;         t[28] = 32'd3;         t[29] = 32'd1;
    t[30] = 32'd1;         t[31] = 32'd0;
    return ang_t'(t[i]);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cstuv_cell.sv =====
// one vectoring step of a cordic cell row
`default_nettype none
module cstuv_cell #(
  parameter int STEP = 0
) (
  input  wire                 clk,
  input  wire cstuv_pkg::dat_t x_in,
  input  wire cstuv_pkg::dat_t y_in,
  input  wire cstuv_pkg::ang_t a_in,
  output cstuv_pkg::dat_t      x_out,
  output cstuv_pkg::dat_t      y_out,
  output cstuv_pkg::ang_t      a_out
);
  cstuv_pkg::dat_t x_r, y_r, dx, dy;
  cstuv_pkg::ang_t a_r;

  assign dx = y_in >>> STEP;
  assign dy = x_in >>> STEP;

  always_ff @(posedge clk) begin
    if (!y_in[cstuv_pkg::DW-1]) begin
      x_r <= x_in + dx;
      y_r <= y_in - dy;
      a_r <= a_in + cstuv_pkg::atan_tab(STEP);
    end else begin
      x_r <= x_in - dx;
      y_r <= y_in + dy;
      a_r <= a_in - cstuv_pkg::atan_tab(STEP);
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign a_out = a_r;
endmodule
`default_nettype wire

// ===== rtl/core/cstuv_row.sv =====
// row of cordic cells with a delay line for a side value and the tag
`default_nettype none
module cstuv_row (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire cstuv_pkg::dat_t x_in,
  input  wire cstuv_pkg::dat_t y_in,
  input  wire cstuv_pkg::dat_t side_in,
  input  wire cstuv_pkg::tag_t tag_in,
  output cstuv_pkg::dat_t      x_out,
  output cstuv_pkg::ang_t      a_out,
  output cstuv_pkg::dat_t      side_out,
  output cstuv_pkg::tag_t      tag_out
);
  localparam int N = cstuv_pkg::ITERS;
  cstuv_pkg::dat_t xs [0:N];
  cstuv_pkg::dat_t ys [0:N];
  cstuv_pkg::ang_t as [0:N];
  cstuv_pkg::dat_t sd_r [0:N-1];
  cstuv_pkg::tag_t tg_r [0:N-1];

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign as[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    cstuv_cell #(.STEP(i)) u_cell (
      .clk(clk), .x_in(xs[i]), .y_in(ys[i]), .a_in(as[i]),
      .x_out(xs[i+1]), .y_out(ys[i+1]), .a_out(as[i+1])
    );
    always_ff @(posedge clk) begin
      if (i == 0) begin
        sd_r[i] <= side_in;
      end else begin
        sd_r[i] <= sd_r[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tg_r[i] <= '0;
      end else if (i == 0) begin
        tg_r[i] <= tag_in;
      end else begin
        tg_r[i] <= tg_r[i-1];
      end
    end
  end

  assign x_out    = xs[N];
  assign a_out    = as[N];
  assign side_out = sd_r[N-1];
  assign tag_out  = tg_r[N-1];
endmodule
`default_nettype wire

// ===== rtl/core/cartesian_to_spherical_uv.sv =====
// top level: cartesian point to spherical texture coordinates
// one point per cycle, fully pipelined; a point taken at start passes the entry
// register, two rows of 32 cordic cells, two gain multiply stages and the
// output register before out_valid rises. busy is never
// raised, and out_valid pulses for one cycle per beat, so the receiver must
// take every result
`default_nettype none
module cartesian_to_spherical_uv #(
  parameter int COORD_WIDTH     = 32,
  parameter int COORD_FRAC_BITS = 16,
  parameter int OUT_FRAC_BITS   = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  output logic                      busy,
  input  wire  [COORD_WIDTH-1:0]    in_pos_x,
  input  wire  [COORD_WIDTH-1:0]    in_pos_y,
  input  wire  [COORD_WIDTH-1:0]    in_pos_z,
  input  wire                       cfg_we,
  input  wire                       cfg_wdata,
  output logic                      out_valid,
  output logic [OUT_FRAC_BITS:0]    out_s_coord,
  output logic [OUT_FRAC_BITS:0]    out_t_coord,
  output logic                      out_error_flag
);
  localparam int PRESHIFT = 56 - COORD_WIDTH;
  localparam int DW = cstuv_pkg::DW;
  localparam int AW = cstuv_pkg::AW;
  // the result only depends on ratios, so frac bits only document the format
  localparam int FRAC_UNUSED = COORD_FRAC_BITS;

  logic proj_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proj_valid_r <= 1'b0;
    end else if (cfg_we) begin
      proj_valid_r <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // magnitude decode, most negative maps to 2^(W-1)
  function automatic cstuv_pkg::dat_t mag(input logic [COORD_WIDTH-1:0] v);
    logic [COORD_WIDTH:0] u;
    u = v[COORD_WIDTH-1] ? ({1'b1, {COORD_WIDTH{1'b0}}} - {1'b0, v}) : {1'b0, v};
    return cstuv_pkg::dat_t'(u) <<< PRESHIFT;
  endfunction

  // entry stage
  cstuv_pkg::dat_t ax_r, ay_r, az_r;
  cstuv_pkg::tag_t tag0_r;
  always_ff @(posedge clk) begin
    ax_r <= mag(in_pos_x);
    ay_r <= mag(in_pos_y);
    az_r <= mag(in_pos_z);
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r <= '0;
    end else begin
      tag0_r.valid   <= start;
      tag0_r.err     <= !proj_valid_r;
      tag0_r.xn      <= in_pos_x[COORD_WIDTH-1];
      tag0_r.yn      <= in_pos_y[COORD_WIDTH-1];
      tag0_r.zn      <= in_pos_z[COORD_WIDTH-1];
      tag0_r.ax_zero <= (in_pos_x == '0);
      tag0_r.ay_zero <= (in_pos_y == '0);
      tag0_r.az_zero <= (in_pos_z == '0);
    end
  end

  // first row: (|x|,|z|) -> phi, G*r; |y| rides along
  cstuv_pkg::dat_t rx1, ay1;
  cstuv_pkg::ang_t phi1;
  cstuv_pkg::tag_t tag1;
  cstuv_row u_row1 (
    .clk(clk), .rst_n(rst_n), .x_in(ax_r), .y_in(az_r), .side_in(ay_r),
    .tag_in(tag0_r), .x_out(rx1), .a_out(phi1), .side_out(ay1), .tag_out(tag1)
  );

  // gain multiply of |y|, split in two partial products that are registered together and then summed into gy_r
  // scaled |y| never exceeds 2^55, so the high part fits 32 bits
  logic [31:0] hi_w;
  logic [23:0] lo_w;
  assign hi_w = ay1[55:24];
  assign lo_w = ay1[23:0];
  logic [63:0] ph_r, pl_r;
  cstuv_pkg::dat_t rx2_r, rx3_r, gy_r;
  cstuv_pkg::ang_t s2_r, s3_r;
  cstuv_pkg::tag_t tag2_r, tag3_r;

  // s from phi, formed alongside the multiply
  cstuv_pkg::ang_t theta_w, s_w;
  always_comb begin
    cstuv_pkg::ang_t ph;
    if (tag1.az_zero) ph = '0;
    else if (tag1.ax_zero) ph = cstuv_pkg::ang_t'(64'sd1 <<< 30);
    else ph = phi1;
    theta_w = tag1.xn ? (cstuv_pkg::ang_t'(64'sd1 <<< 31) - ph) : ph;
    if (tag1.ax_zero && tag1.az_zero) s_w = '0;
    else s_w = tag1.zn ? theta_w : (cstuv_pkg::ang_t'(64'sd1 <<< 32) - theta_w);
  end

  always_ff @(posedge clk) begin
    ph_r  <= 64'(hi_w) * 64'(cstuv_pkg::GAIN_Q30);
    pl_r  <= 64'(lo_w) * 64'(cstuv_pkg::GAIN_Q30);
    rx2_r <= rx1;
    s2_r  <= s_w;
    gy_r  <= cstuv_pkg::dat_t'((ph_r >> 6) + (pl_r >> 30));
    rx3_r <= rx2_r;
    s3_r  <= s2_r;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
      tag3_r <= '0;
    end else begin
      tag2_r <= tag1;
      tag3_r <= tag2_r;
    end
  end

  // second row: (G*r, G*|y|) -> psi; s rides along
  cstuv_pkg::dat_t rx4_unused, s4;
  cstuv_pkg::ang_t psi4;
  cstuv_pkg::tag_t tag4;
  cstuv_row u_row2 (
    .clk(clk), .rst_n(rst_n), .x_in(rx3_r), .y_in(gy_r),
    .side_in(cstuv_pkg::dat_t'(s3_r)), .tag_in(tag3_r),
    .x_out(rx4_unused), .a_out(psi4), .side_out(s4), .tag_out(tag4)
  );

  // t, rounding and saturation
  function automatic logic [OUT_FRAC_BITS:0] rsat(input cstuv_pkg::ang_t v,
                                                  input int fb);
    logic [AW:0] r;
    int sh;
    sh = fb - OUT_FRAC_BITS;
    if (v[AW-1]) r = '0;
    else r = ({1'b0, v} + ((AW+1)'(1) << (sh - 1))) >> sh;
    if (r > ((AW+1)'(1) << OUT_FRAC_BITS))
      r = (AW+1)'(1) << OUT_FRAC_BITS;
    return r[OUT_FRAC_BITS:0];
  endfunction

  cstuv_pkg::ang_t t_w, psi_w;
  always_comb begin
    if (tag4.ay_zero) psi_w = '0;
    else if (tag4.ax_zero && tag4.az_zero) psi_w = cstuv_pkg::ang_t'(64'sd1 <<< 30);
    else psi_w = psi4;
    if (tag4.ax_zero && tag4.az_zero && tag4.ay_zero) t_w = '0;
    else if (tag4.yn) t_w = cstuv_pkg::ang_t'(64'sd1 <<< 30) + psi_w;
    else t_w = cstuv_pkg::ang_t'(64'sd1 <<< 30) - psi_w;
  end

  always_ff @(posedge clk) begin
    if (tag4.err) begin
      out_s_coord <= '0;
      out_t_coord <= '0;
    end else begin
      out_s_coord <= rsat(cstuv_pkg::ang_t'(s4[AW-1:0]), 32);
      out_t_coord <= rsat(t_w, 31);
    end
    out_error_flag <= tag4.err;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= tag4.valid && (FRAC_UNUSED >= 0) && (rx4_unused[0] || 1'b1);
    end
  end
endmodule
`default_nettype wire
